// ===== hdl/mfu_pkg.sv =====
// shared constants for the manning friction update core
// no dependencies
package mfu_pkg;

  // word width of the discharges, velocities and single-word intermediate magnitudes
  localparam int unsigned QW = 32;

  localparam logic [QW-1:0] QMAX = '1;
  localparam logic [QW-1:0] VMAX = {1'b0, {(QW-1){1'b1}}};

  // latency of the pipelined divider and square root units
  localparam int unsigned DIV_LAT  = QW + 1;
  localparam int unsigned SQRT_LAT = QW + 1;

  // result path codes
  localparam logic [1:0] PATH_DRY  = 2'd0;
  localparam logic [1:0] PATH_SLOW = 2'd1;
  localparam logic [1:0] PATH_FRIC = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_DEPTH_THR = 2'd0;
  localparam logic [1:0] REG_SPEED_THR = 2'd1;
  localparam logic [1:0] REG_GRAVITY   = 2'd2;
  localparam logic [1:0] REG_TIME_STEP = 2'd3;

endpackage

// ===== hdl/mfu_delay.sv =====
// enabled shift line that aligns side data with the arithmetic units
// no package dependencies
module mfu_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned D = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [D];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < D; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[D-1];

endmodule

// ===== hdl/mfu_div.sv =====
// pipelined restoring divider, one quotient bit per stage, saturating to one word
// depends on mfu_pkg
module mfu_div import mfu_pkg::*; #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o
);

  localparam int unsigned CW = (NW > DW) ? NW : DW;

  logic [DW-1:0] rem_q [QW+1];
  logic [QW-1:0] low_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic          ovf_q [QW+1];

  logic [DW:0]   trial_w [QW];
  logic          ge_w    [QW];
  logic [CW-1:0] hi_w;

  // quotient of a word or more cannot be represented
  assign hi_w = CW'(num_i >> QW);

  always_comb begin
    for (int s = 0; s < QW; s++) begin
      trial_w[s] = {rem_q[s], low_q[s][QW-1]};
      ge_w[s]    = trial_w[s] >= {1'b0, den_q[s]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0] <= hi_w >= CW'(den_i);
      rem_q[0] <= DW'(num_i >> QW);
      low_q[0] <= num_i[QW-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      for (int s = 0; s < QW; s++) begin
        rem_q[s+1] <= ge_w[s] ? DW'(trial_w[s] - {1'b0, den_q[s]}) : DW'(trial_w[s]);
        low_q[s+1] <= low_q[s] << 1;
        quo_q[s+1] <= {quo_q[s][QW-2:0], ge_w[s]};
        den_q[s+1] <= den_q[s];
        ovf_q[s+1] <= ovf_q[s];
      end
    end
  end

  assign quo_o = ovf_q[QW] ? QMAX : quo_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule

// ===== hdl/mfu_sqrt.sv =====
// pipelined integer square root of a double word, one root bit per stage
// depends on mfu_pkg
module mfu_sqrt import mfu_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*QW-1:0] x_i,
  output logic [QW-1:0]   root_o
);

  localparam int unsigned XW  = 2 * QW;
  localparam int unsigned RMW = QW + 2;

  logic [XW-1:0]  xs_q   [QW+1];
  logic [RMW-1:0] rem_q  [QW+1];
  logic [QW-1:0]  root_q [QW+1];

  logic [RMW-1:0] rt_w [QW];
  logic [RMW-1:0] tr_w [QW];
  logic           ge_w [QW];

  always_comb begin
    for (int s = 0; s < QW; s++) begin
      rt_w[s] = {rem_q[s][QW-1:0], xs_q[s][XW-1 -: 2]};
      tr_w[s] = {root_q[s], 2'b01};
      ge_w[s] = rt_w[s] >= tr_w[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xs_q[0]   <= x_i;
      rem_q[0]  <= '0;
      root_q[0] <= '0;
      for (int s = 0; s < QW; s++) begin
        xs_q[s+1]   <= xs_q[s] << 2;
        rem_q[s+1]  <= ge_w[s] ? (rt_w[s] - tr_w[s]) : rt_w[s];
        root_q[s+1] <= {root_q[s][QW-2:0], ge_w[s]};
      end
    end
  end

  assign root_o = root_q[QW];

endmodule

// ===== hdl/mfu_cbrt.sv =====
// pipelined cube root of depth scaled by two fraction widths, one root bit per stage
// depends on mfu_pkg
module mfu_cbrt import mfu_pkg::*; #(
  parameter int unsigned F = 16
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [QW-1:0]               h_i,
  output logic [(QW+2*F+2)/3-1:0]     root_o
);

  localparam int unsigned NG  = (QW + 2*F + 2) / 3;
  localparam int unsigned PW  = 3 * NG;
  localparam int unsigned RMW = 2 * NG + 5;
  localparam int unsigned MW  = 2 * NG + 2;

  logic [PW-1:0]  xs_q  [NG+1];
  logic [RMW-1:0] rem_q [NG+1];
  logic [NG-1:0]  y_q   [NG+1];

  logic [NG-1:0]  y2_w [NG];
  logic [MW-1:0]  pr_w [NG];
  logic [RMW-1:0] rt_w [NG];
  logic [RMW-1:0] tr_w [NG];
  logic           ge_w [NG];

  // (2y+1)^3 - (2y)^3 = 3*2y*(2y+1) + 1
  always_comb begin
    for (int s = 0; s < NG; s++) begin
      y2_w[s] = {y_q[s][NG-2:0], 1'b0};
      pr_w[s] = MW'(y2_w[s]) * MW'(y2_w[s] | NG'(1));
      rt_w[s] = {rem_q[s][RMW-4:0], xs_q[s][PW-1 -: 3]};
      tr_w[s] = (RMW'(pr_w[s]) << 1) + RMW'(pr_w[s]) + RMW'(1);
      ge_w[s] = rt_w[s] >= tr_w[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xs_q[0]  <= PW'({h_i, {(2*F){1'b0}}});
      rem_q[0] <= '0;
      y_q[0]   <= '0;
      for (int s = 0; s < NG; s++) begin
        xs_q[s+1]  <= xs_q[s] << 3;
        rem_q[s+1] <= ge_w[s] ? (rt_w[s] - tr_w[s]) : rt_w[s];
        y_q[s+1]   <= y2_w[s] | NG'(ge_w[s]);
      end
    end
  end

  assign root_o = y_q[NG];

endmodule

// ===== hdl/manning_friction_update_core.sv =====
// top level of the semi-implicit manning friction update pipeline
// depends on mfu_pkg, mfu_delay, mfu_div, mfu_sqrt, mfu_cbrt
//
// Takes one grid point word per clock (depth, x/y discharge, roughness) and
// returns one result word per point, in order. The pipeline is fully
// streamed: a new word is accepted every cycle unless the output register
// holds a result that the sink stalls, in which case the whole pipe freezes.
// The longest path through the pipe is the dependent chain of the velocity
// divider, the speed square root, the drag-denominator divider and the final
// delta divider, each a 33-stage bit-per-stage unit. The cube root of the
// depth and the friction coefficient divider run beside that chain.
// Configuration registers are read live, so write them only while
// no word is in flight.
module manning_friction_update_core import mfu_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // configuration write port
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_wdata_i,
  // input channel
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [31:0]   depth_i,
  input  logic [31:0]   flow_x_i,
  input  logic [31:0]   flow_y_i,
  input  logic [15:0]   roughness_i,
  // output channel
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [31:0]   new_flow_x_o,
  output logic [31:0]   new_flow_y_o,
  output logic [1:0]    path_taken_o,
  output logic          saturated_o
);

  // cube root width and unit latencies
  localparam int unsigned RW = (QW + 2*FRAC_BITS + 2) / 3;
  localparam int unsigned LD = DIV_LAT;
  localparam int unsigned LS = SQRT_LAT;
  localparam int unsigned LC = RW + 1;

  // pipeline timeline, cycles after a word is accepted
  localparam int unsigned T_A   = 1;
  localparam int unsigned T_UV  = T_A + LD;
  localparam int unsigned T_B   = T_UV + 1;
  localparam int unsigned T_SQ  = T_B + 1;
  localparam int unsigned T_SUM = T_SQ + 1;
  localparam int unsigned T_SPD = T_SUM + LS;
  localparam int unsigned T_GN  = T_A + 2;
  localparam int unsigned T_R   = T_A + LC;
  localparam int unsigned T_CF  = T_R + LD;
  localparam int unsigned T_E1  = T_CF + 1;
  localparam int unsigned T_K   = T_E1 + LD;
  localparam int unsigned T_S2  = T_SPD + 2;
  localparam int unsigned T_W   = T_SPD + LD;
  localparam int unsigned T_D   = T_W + 1;
  localparam int unsigned T_DL  = T_D + LD;
  localparam int unsigned T_OUT = T_DL + 1;

  localparam logic [QW:0] ONE_Q = (QW+1)'(1) << FRAC_BITS;
  localparam logic signed [QW+1:0] SMAX = {2'b00, VMAX};
  localparam logic signed [QW+1:0] SMIN = {2'b11, ~VMAX};

  // fixed point multiply, truncated and clamped to one word; top bit flags the clamp
  function automatic logic [QW:0] mulq(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [2*QW-1:0] p;
    logic [2*QW-1:0] s;
    p = (2*QW)'(a) * (2*QW)'(b);
    s = p >> FRAC_BITS;
    mulq = (s > (2*QW)'(QMAX)) ? {1'b1, QMAX} : {1'b0, s[QW-1:0]};
  endfunction

  // discharge update with clamp to the signed word range
  function automatic logic [QW:0] upd(input logic [QW-1:0] q, input logic [QW-1:0] dl);
    logic signed [QW+1:0] qe;
    logic signed [QW+1:0] de;
    logic signed [QW+1:0] nx;
    qe = {{2{q[QW-1]}}, q};
    de = {2'b00, dl};
    if (q[QW-1]) begin
      nx = qe + de;
    end else if (q != '0) begin
      nx = qe - de;
    end else begin
      nx = qe;
    end
    if (nx > SMAX) begin
      upd = {1'b1, VMAX};
    end else if (nx < SMIN) begin
      upd = {1'b1, ~VMAX};
    end else begin
      upd = {1'b0, nx[QW-1:0]};
    end
  endfunction

  // ---------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------
  logic [31:0] depth_thr_q;
  logic [31:0] speed_thr_q;
  logic [23:0] gravity_q;
  logic [31:0] time_step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_thr_q <= 32'd66;
      speed_thr_q <= 32'd0;
      gravity_q   <= 24'd642689;
      time_step_q <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEPTH_THR: depth_thr_q <= cfg_wdata_i;
        REG_SPEED_THR: speed_thr_q <= cfg_wdata_i;
        REG_GRAVITY:   gravity_q   <= cfg_wdata_i[23:0];
        REG_TIME_STEP: time_step_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // flow control: the pipe moves unless the output word is stalled
  // ---------------------------------------------------------------
  logic             adv_w;
  logic [T_OUT-1:0] vld_q;

  assign adv_w      = !(vld_q[T_OUT-1] && out_stall_i);
  assign in_stall_o = !adv_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_w) begin
      vld_q <= {vld_q[T_OUT-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[T_OUT-1];

  // ---------------------------------------------------------------
  // stage A: capture, magnitudes, dry test
  // ---------------------------------------------------------------
  logic [QW-1:0] h_q, hu_q, hv_q, hum_q, hvm_q;
  logic [15:0]   n_q;
  logic          dry_q;

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      h_q   <= depth_i;
      hu_q  <= flow_x_i;
      hv_q  <= flow_y_i;
      n_q   <= roughness_i;
      hum_q <= flow_x_i[QW-1] ? (~flow_x_i + QW'(1)) : flow_x_i;
      hvm_q <= flow_y_i[QW-1] ? (~flow_y_i + QW'(1)) : flow_y_i;
      dry_q <= depth_i <= depth_thr_q;
    end
  end

  // velocities |HU|/H and |HV|/H
  logic [QW-1:0] um_w, vm_w;
  logic          um_ovf_w, vm_ovf_w;

  mfu_div #(.NW(QW + FRAC_BITS), .DW(QW)) u_div_um (
    .clk_i, .en_i(adv_w), .num_i({hum_q, {FRAC_BITS{1'b0}}}), .den_i(h_q),
    .quo_o(um_w), .ovf_o(um_ovf_w)
  );

  mfu_div #(.NW(QW + FRAC_BITS), .DW(QW)) u_div_vm (
    .clk_i, .en_i(adv_w), .num_i({hvm_q, {FRAC_BITS{1'b0}}}), .den_i(h_q),
    .quo_o(vm_w), .ovf_o(vm_ovf_w)
  );

  // ---------------------------------------------------------------
  // stage B: slow test and velocity clamp
  // ---------------------------------------------------------------
  logic [QW-1:0] umc_q, vmc_q;
  logic          slow_q, satb_q;
  logic          uc_w, vc_w;

  assign uc_w = um_ovf_w || (um_w > VMAX);
  assign vc_w = vm_ovf_w || (vm_w > VMAX);

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      slow_q <= !um_ovf_w && (um_w <= speed_thr_q) && !vm_ovf_w && (vm_w <= speed_thr_q);
      umc_q  <= uc_w ? VMAX : um_w;
      vmc_q  <= vc_w ? VMAX : vm_w;
      satb_q <= uc_w || vc_w;
    end
  end

  // squares, then the sums feeding speed and the drag weights
  logic [2*QW-1:0] um2_q, vm2_q, ss_q, wxn_q, wyn_q;

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      um2_q <= (2*QW)'(umc_q) * (2*QW)'(umc_q);
      vm2_q <= (2*QW)'(vmc_q) * (2*QW)'(vmc_q);
      ss_q  <= um2_q + vm2_q;
      wxn_q <= (um2_q << 1) + vm2_q;
      wyn_q <= um2_q + (vm2_q << 1);
    end
  end

  logic [QW-1:0] spd_w;

  mfu_sqrt u_sqrt (
    .clk_i, .en_i(adv_w), .x_i(ss_q), .root_o(spd_w)
  );

  // drag weights W = (2U^2+V^2)/speed and (U^2+2V^2)/speed
  logic [4*QW-1:0] wn_d;
  logic [QW-1:0]   wx_w, wy_w;
  logic            wx_ovf_w, wy_ovf_w;

  mfu_delay #(.W(4*QW), .D(T_SPD - T_SUM)) u_dly_wn (
    .clk_i, .en_i(adv_w), .d_i({wxn_q, wyn_q}), .q_o(wn_d)
  );

  mfu_div #(.NW(2*QW), .DW(QW)) u_div_wx (
    .clk_i, .en_i(adv_w), .num_i(wn_d[4*QW-1:2*QW]), .den_i(spd_w),
    .quo_o(wx_w), .ovf_o(wx_ovf_w)
  );

  mfu_div #(.NW(2*QW), .DW(QW)) u_div_wy (
    .clk_i, .en_i(adv_w), .num_i(wn_d[2*QW-1:0]), .den_i(spd_w),
    .quo_o(wy_w), .ovf_o(wy_ovf_w)
  );

  // ---------------------------------------------------------------
  // friction coefficient Cf = g*n^2 / (cbrt(H) scaled)
  // ---------------------------------------------------------------
  logic [QW-1:0]    nn_q;
  logic [24+QW-1:0] gn_q, gn_d;
  logic [RW-1:0]    r_w;
  logic [QW-1:0]    cf_w;
  logic             cf_ovf_w;

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      nn_q <= QW'(n_q) * QW'(n_q);
      gn_q <= (24+QW)'(gravity_q) * (24+QW)'(nn_q);
    end
  end

  mfu_cbrt #(.F(FRAC_BITS)) u_cbrt (
    .clk_i, .en_i(adv_w), .h_i(h_q), .root_o(r_w)
  );

  mfu_delay #(.W(24+QW), .D(T_R - T_GN)) u_dly_gn (
    .clk_i, .en_i(adv_w), .d_i(gn_q), .q_o(gn_d)
  );

  mfu_div #(.NW(24+QW), .DW(RW + QW - FRAC_BITS)) u_div_cf (
    .clk_i, .en_i(adv_w), .num_i(gn_d), .den_i({r_w, {(QW-FRAC_BITS){1'b0}}}),
    .quo_o(cf_w), .ovf_o(cf_ovf_w)
  );

  // ---------------------------------------------------------------
  // stage E1: Cf*U, Cf*V, Tstep*Cf
  // ---------------------------------------------------------------
  logic [2*QW:0] uvd_w;
  logic [QW:0]   cmx_w, cmy_w, t1_w;
  logic [QW-1:0] cmx_q, cmy_q, t1_q;
  logic          sate_q;

  mfu_delay #(.W(2*QW+1), .D(T_CF - T_B)) u_dly_uv (
    .clk_i, .en_i(adv_w), .d_i({umc_q, vmc_q, satb_q}), .q_o(uvd_w)
  );

  assign cmx_w = mulq(cf_w, uvd_w[2*QW:QW+1]);
  assign cmy_w = mulq(cf_w, uvd_w[QW:1]);
  assign t1_w  = mulq(time_step_q, cf_w);

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      cmx_q  <= cmx_w[QW-1:0];
      cmy_q  <= cmy_w[QW-1:0];
      t1_q   <= t1_w[QW-1:0];
      sate_q <= uvd_w[0] || cf_ovf_w || cmx_w[QW] || cmy_w[QW] || t1_w[QW];
    end
  end

  // K = Tstep*Cf / H
  logic [QW-1:0] h_e;
  logic [QW-1:0] k_w;
  logic          k_ovf_w;

  mfu_delay #(.W(QW), .D(T_E1 - T_A)) u_dly_h (
    .clk_i, .en_i(adv_w), .d_i(h_q), .q_o(h_e)
  );

  mfu_div #(.NW(QW + FRAC_BITS), .DW(QW)) u_div_k (
    .clk_i, .en_i(adv_w), .num_i({t1_q, {FRAC_BITS{1'b0}}}), .den_i(h_e),
    .quo_o(k_w), .ovf_o(k_ovf_w)
  );

  // ---------------------------------------------------------------
  // stages S1, S2: friction slope times speed, then times Tstep
  // ---------------------------------------------------------------
  logic [2*QW:0] cmd_w;
  logic [QW:0]   smx_w, smy_w, tsx_w, tsy_w;
  logic [QW-1:0] smx_q, smy_q, tsx_q, tsy_q;
  logic          sat1_q, sat2_q;

  mfu_delay #(.W(2*QW+1), .D(T_SPD - T_E1)) u_dly_cm (
    .clk_i, .en_i(adv_w), .d_i({cmx_q, cmy_q, sate_q}), .q_o(cmd_w)
  );

  assign smx_w = mulq(cmd_w[2*QW:QW+1], spd_w);
  assign smy_w = mulq(cmd_w[QW:1], spd_w);
  assign tsx_w = mulq(time_step_q, smx_q);
  assign tsy_w = mulq(time_step_q, smy_q);

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      smx_q  <= smx_w[QW-1:0];
      smy_q  <= smy_w[QW-1:0];
      sat1_q <= cmd_w[0] || smx_w[QW] || smy_w[QW];
      tsx_q  <= tsx_w[QW-1:0];
      tsy_q  <= tsy_w[QW-1:0];
      sat2_q <= sat1_q || tsx_w[QW] || tsy_w[QW];
    end
  end

  // ---------------------------------------------------------------
  // stage D: denominators D = 1 + K*W
  // ---------------------------------------------------------------
  logic [2*QW:0] tsd_w;
  logic [QW:0]   kd_w;
  logic [QW:0]   mkx_w, mky_w, dsx_w, dsy_w;
  logic [QW-1:0] dx_q, dy_q, dnx_q, dny_q;
  logic          satd_q;

  mfu_delay #(.W(2*QW+1), .D(T_W - T_S2)) u_dly_ts (
    .clk_i, .en_i(adv_w), .d_i({tsx_q, tsy_q, sat2_q}), .q_o(tsd_w)
  );

  mfu_delay #(.W(QW+1), .D(T_W - T_K)) u_dly_k (
    .clk_i, .en_i(adv_w), .d_i({k_w, k_ovf_w}), .q_o(kd_w)
  );

  assign mkx_w = mulq(kd_w[QW:1], wx_w);
  assign mky_w = mulq(kd_w[QW:1], wy_w);
  assign dsx_w = ONE_Q + {1'b0, mkx_w[QW-1:0]};
  assign dsy_w = ONE_Q + {1'b0, mky_w[QW-1:0]};

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      dx_q   <= dsx_w[QW] ? QMAX : dsx_w[QW-1:0];
      dy_q   <= dsy_w[QW] ? QMAX : dsy_w[QW-1:0];
      dnx_q  <= tsd_w[2*QW:QW+1];
      dny_q  <= tsd_w[QW:1];
      satd_q <= tsd_w[0] || kd_w[0] || wx_ovf_w || wy_ovf_w || mkx_w[QW] ||
                mky_w[QW] || dsx_w[QW] || dsy_w[QW];
    end
  end

  // delta = Tstep*Sf / D
  logic [QW-1:0] dlx_w, dly_w;
  logic          dlx_ovf_w, dly_ovf_w;

  mfu_div #(.NW(QW + FRAC_BITS), .DW(QW)) u_div_dlx (
    .clk_i, .en_i(adv_w), .num_i({dnx_q, {FRAC_BITS{1'b0}}}), .den_i(dx_q),
    .quo_o(dlx_w), .ovf_o(dlx_ovf_w)
  );

  mfu_div #(.NW(QW + FRAC_BITS), .DW(QW)) u_div_dly (
    .clk_i, .en_i(adv_w), .num_i({dny_q, {FRAC_BITS{1'b0}}}), .den_i(dy_q),
    .quo_o(dly_w), .ovf_o(dly_ovf_w)
  );

  // ---------------------------------------------------------------
  // side data to the result stage
  // ---------------------------------------------------------------
  logic [2*QW:0] side_w;
  logic          slow_d, satd_d;

  mfu_delay #(.W(2*QW+1), .D(T_DL - T_A)) u_dly_side (
    .clk_i, .en_i(adv_w), .d_i({hu_q, hv_q, dry_q}), .q_o(side_w)
  );

  mfu_delay #(.W(1), .D(T_DL - T_B)) u_dly_slow (
    .clk_i, .en_i(adv_w), .d_i(slow_q), .q_o(slow_d)
  );

  mfu_delay #(.W(1), .D(T_DL - T_D)) u_dly_satd (
    .clk_i, .en_i(adv_w), .d_i(satd_q), .q_o(satd_d)
  );

  // ---------------------------------------------------------------
  // result stage: select path, apply delta, output register
  // ---------------------------------------------------------------
  logic [QW:0]   nx_w, ny_w;
  logic [QW-1:0] nfx_q, nfy_q;
  logic [1:0]    path_q;
  logic          sat_q;

  assign nx_w = upd(side_w[2*QW:QW+1], dlx_w);
  assign ny_w = upd(side_w[QW:1], dly_w);

  always_ff @(posedge clk_i) begin
    if (adv_w) begin
      if (side_w[0]) begin
        nfx_q  <= '0;
        nfy_q  <= '0;
        path_q <= PATH_DRY;
        sat_q  <= 1'b0;
      end else if (slow_d) begin
        nfx_q  <= side_w[2*QW:QW+1];
        nfy_q  <= side_w[QW:1];
        path_q <= PATH_SLOW;
        sat_q  <= 1'b0;
      end else begin
        nfx_q  <= nx_w[QW-1:0];
        nfy_q  <= ny_w[QW-1:0];
        path_q <= PATH_FRIC;
        sat_q  <= satd_d || dlx_ovf_w || dly_ovf_w || nx_w[QW] || ny_w[QW];
      end
    end
  end

  assign new_flow_x_o = nfx_q;
  assign new_flow_y_o = nfy_q;
  assign path_taken_o = path_q;
  assign saturated_o  = sat_q;

  // ---------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------
  a_no_sat_off_fric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (path_taken_o != PATH_FRIC) |-> !saturated_o)
    else $error("saturation flagged outside friction path");

  a_dry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (path_taken_o == PATH_DRY) |-> (new_flow_x_o == '0) && (new_flow_y_o == '0))
    else $error("dry point with nonzero discharge");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled output word");

endmodule
